>>> sv/bop_pkg.sv
package bop_pkg;

  localparam int DEF_MAX_HORIZON = 63;
  localparam int DEF_FRAC_BITS   = 16;

  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int STEP_W   = 6;
  localparam int TIME_W   = 16;
  localparam int GAIN_W   = 24;
  localparam int WORD_W   = 32;
  localparam int MUL_A_W  = WORD_W + 1;
  localparam int MUL_B_W  = GAIN_W;
  localparam int PROD_W   = MUL_A_W + MUL_B_W + 1;
  localparam int S_DATA_W = 160;
  localparam int M_DATA_W = 104;

  localparam logic [TIME_W-1:0] RST_FINE_STEP_TIME   = 16'd655;
  localparam logic [TIME_W-1:0] RST_COARSE_STEP_TIME = 16'd3277;
  localparam logic [STEP_W-1:0] RST_FINE_STEPS       = 6'd10;
  localparam logic [STEP_W-1:0] RST_HORIZON          = 6'd20;
  localparam logic [GAIN_W-1:0] RST_EXPAND_GAIN      = 24'd0;

  typedef enum logic [2:0] {
    REG_FINE_STEP_TIME   = 3'd0,
    REG_COARSE_STEP_TIME = 3'd1,
    REG_FINE_STEPS       = 3'd2,
    REG_HORIZON          = 3'd3,
    REG_EXPAND_GAIN      = 3'd4,
    REG_VARIABLE_STEP    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] fine_step_time;
    logic [TIME_W-1:0] coarse_step_time;
    logic [STEP_W-1:0] fine_steps;
    logic [STEP_W-1:0] horizon;
    logic [GAIN_W-1:0] expand_gain;
    logic              variable_step;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXPMUL,
    S_EXP,
    S_MUL,
    S_ADV
  } state_t;

endpackage

>>> sv/bop_cfg.sv
module bop_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bop_pkg::ADDR_W-1:0]  paddr,
  input  logic [bop_pkg::DATA_W-1:0]  pwdata,
  output logic [bop_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bop_pkg::cfg_t               cfg
);
  import bop_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fine_step_time   <= RST_FINE_STEP_TIME;
      cfg.coarse_step_time <= RST_COARSE_STEP_TIME;
      cfg.fine_steps       <= RST_FINE_STEPS;
      cfg.horizon          <= RST_HORIZON;
      cfg.expand_gain      <= RST_EXPAND_GAIN;
      cfg.variable_step    <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_FINE_STEP_TIME:   cfg.fine_step_time   <= pwdata[TIME_W-1:0];
        REG_COARSE_STEP_TIME: cfg.coarse_step_time <= pwdata[TIME_W-1:0];
        REG_FINE_STEPS:       cfg.fine_steps       <= pwdata[STEP_W-1:0];
        REG_HORIZON:          cfg.horizon          <= pwdata[STEP_W-1:0];
        REG_EXPAND_GAIN:      cfg.expand_gain      <= pwdata[GAIN_W-1:0];
        REG_VARIABLE_STEP:    cfg.variable_step    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_FINE_STEP_TIME:   prdata = DATA_W'(cfg.fine_step_time);
      REG_COARSE_STEP_TIME: prdata = DATA_W'(cfg.coarse_step_time);
      REG_FINE_STEPS:       prdata = DATA_W'(cfg.fine_steps);
      REG_HORIZON:          prdata = DATA_W'(cfg.horizon);
      REG_EXPAND_GAIN:      prdata = DATA_W'(cfg.expand_gain);
      REG_VARIABLE_STEP:    prdata = DATA_W'(cfg.variable_step);
      default:              prdata = '0;
    endcase
  end

endmodule

>>> sv/bop_mul.sv
module bop_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [bop_pkg::MUL_A_W-1:0] a,
  input  logic        [bop_pkg::MUL_B_W-1:0] b,
  output logic signed [bop_pkg::PROD_W-1:0]  prod
);
  import bop_pkg::*;

  logic signed [MUL_B_W:0] b_s;

  assign b_s = $signed({1'b0, b});

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a * b_s);
    end
  end

endmodule

>>> sv/bounded_obstacle_predictor_unit.sv
// Channel   Dir  Payload (low bit up)
// s_axis    in   tdata: position, velocity, extent, lower_bound, upper_bound; tuser: bounds_finite
// m_axis    out  tdata: step_index, pred_position, pred_velocity, pred_extent; tlast: last
// apb       in   config registers at byte address 4*i
//
// A single shared 33x25 multiplier serves the size gain and then every step,
// one product per step, so the multiplier loop and any output stall set the rate.
// s_tready is high only while the sequencer is idle.
// A stalled m_tready holds the sequencer at its next write to the output register.
// rst is synchronous; it clears the sequencer and output valid and resets the config registers to their defaults.
module bounded_obstacle_predictor_unit #(
  parameter int MAX_HORIZON = bop_pkg::DEF_MAX_HORIZON,
  parameter int FRAC_BITS   = bop_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bop_pkg::S_DATA_W-1:0]  s_tdata,   // position, velocity, extent, lower, upper
  input  logic                          s_tuser,   // bounds_finite
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bop_pkg::M_DATA_W-1:0]  m_tdata,   // step_index, position, velocity, extent
  output logic                          m_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bop_pkg::ADDR_W-1:0]    paddr,
  input  logic [bop_pkg::DATA_W-1:0]    pwdata,
  output logic [bop_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import bop_pkg::*;

  localparam logic signed [WORD_W-1:0] SMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] SMIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [STEP_W-1:0]        HZ_MAX = STEP_W'(MAX_HORIZON);

  cfg_t   cfg;
  state_t state, state_next;

  logic signed [WORD_W-1:0] pos, vel, lo, hi;
  logic        [WORD_W-1:0] ext;
  logic                     finite;
  logic        [STEP_W-1:0] hz, k;

  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic        [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic                      out_free, out_load, in_acc;
  logic signed [MUL_A_W-1:0] vel_x, mag;
  logic        [TIME_W-1:0]  dt;
  logic        [PROD_W-1:0]  ext_sum;
  logic        [WORD_W-1:0]  ext_sat;
  logic signed [PROD_W:0]    pos_sum;
  logic signed [WORD_W-1:0]  pos_sat, pos_new, vel_new;

  logic [STEP_W-1:0] o_step;
  logic [WORD_W-1:0] o_pos, o_vel, o_ext;

  bop_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  bop_mul u_mul (.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .prod(prod));

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign vel_x = MUL_A_W'(vel);
  assign mag   = vel_x[MUL_A_W-1] ? -vel_x : vel_x;
  assign dt    = (!cfg.variable_step || k <= cfg.fine_steps) ? cfg.fine_step_time
                                                             : cfg.coarse_step_time;

  assign ext_sum = PROD_W'(ext) + (prod >> FRAC_BITS);
  assign ext_sat = (ext_sum[PROD_W-1:WORD_W] != '0) ? '1 : ext_sum[WORD_W-1:0];

  assign pos_sum = (PROD_W+1)'(pos) + (PROD_W+1)'(prod >>> FRAC_BITS);
  assign pos_sat = (pos_sum > (PROD_W+1)'(SMAX)) ? SMAX :
                   (pos_sum < (PROD_W+1)'(SMIN)) ? SMIN : pos_sum[WORD_W-1:0];

  always_comb begin
    pos_new = pos_sat;
    vel_new = vel;
    if (finite && hi >= lo) begin
      if (hi == lo) begin
        pos_new = lo;
        vel_new = '0;
      end else if (pos_sat < lo) begin
        pos_new = lo;
        if (vel < 0) vel_new = (vel == SMIN) ? SMAX : -vel;
      end else if (pos_sat > hi) begin
        pos_new = hi;
        if (vel > 0) vel_new = -vel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    mul_a      = mag;
    mul_b      = cfg.expand_gain;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_acc) state_next = S_EXPMUL;
      end
      S_EXPMUL: begin
        mul_en     = 1'b1;
        state_next = S_EXP;
      end
      S_EXP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = (hz == '0) ? S_IDLE : S_MUL;
        end
      end
      S_MUL: begin
        mul_en     = 1'b1;
        mul_a      = vel_x;
        mul_b      = MUL_B_W'(dt);
        state_next = S_ADV;
      end
      S_ADV: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = (k == hz) ? S_IDLE : S_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos    <= s_tdata[31:0];
      vel    <= s_tdata[63:32];
      ext    <= s_tdata[95:64];
      lo     <= s_tdata[127:96];
      hi     <= s_tdata[159:128];
      finite <= s_tuser;
      hz     <= (cfg.horizon > HZ_MAX) ? HZ_MAX : cfg.horizon;
      k      <= '0;
    end
    if (state == S_EXP && out_free) begin
      ext <= ext_sat;
      k   <= STEP_W'(1);
    end
    if (state == S_ADV && out_free) begin
      pos <= pos_new;
      vel <= vel_new;
      k   <= k + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_step  <= k;
      m_tlast <= (k == hz);
      if (state == S_EXP) begin
        o_pos <= pos;
        o_vel <= vel;
        o_ext <= ext_sat;
      end else begin
        o_pos <= pos_new;
        o_vel <= vel_new;
        o_ext <= ext;
      end
    end
  end

  assign m_tdata = {2'b00, o_ext, o_vel, o_pos, o_step};

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while a beat is pending");

  a_start: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_EXPMUL))
    else $error("accepted item did not start the sequencer");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADV) |-> (k != '0 && k <= hz))
    else $error("step counter out of range");

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (out_load && k == hz) |=> (state == S_IDLE))
    else $error("sequencer ran past the final step");
`endif

endmodule
